### rtl/two_class_viterbi_acs_defines.svh
// ----------------------------------------------------------------------------
// Two-class Viterbi ACS assertion macros
// Shared assertion wrappers for the checker of the two-class Viterbi block.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_VITERBI_ACS_DEFINES_SVH
`define TWO_CLASS_VITERBI_ACS_DEFINES_SVH

// Concurrent assertion that is switched off while reset is high.
`define TCV_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Concurrent assertion that is also checked during reset.
`define TCV_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/tcv_pkg.sv
// ----------------------------------------------------------------------------
// Two-class Viterbi ACS package
// Widths, defaults and shared types of the two-class Viterbi ACS block.
// ----------------------------------------------------------------------------
package tcv_pkg;

   localparam int STATES_PER_CLASS_DEF = 8;
   localparam int SCORE_WIDTH_DEF      = 32;

   // Widths of the channel fields.
   localparam int FIELD_W     = 24;
   localparam int SURV_W      = 16;
   localparam int OUT_SCORE_W = 32;
   localparam int IDX_W       = 32;

   // Per-frame control of each add-compare-select cell.
   typedef struct packed {
      logic first;
      logic self_ok;
      logic left_ok;
   } acs_ctrl_type;

endpackage

### rtl/tcv_if.sv
// ----------------------------------------------------------------------------
// Two-class Viterbi ACS channels
// Valid/ready channels for frames, results and the penalty register.
// ----------------------------------------------------------------------------
interface tcv_req_if import tcv_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] silence_score;
   logic signed [FIELD_W-1:0] speech_score;
   logic                      new_session;

   modport source (output valid, silence_score, speech_score, new_session, input ready);
   modport sink (input valid, silence_score, speech_score, new_session, output ready);
endinterface

interface tcv_rsp_if import tcv_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic        [SURV_W-1:0]      survivor_bits;
   logic signed [OUT_SCORE_W-1:0] silence_end_score;
   logic signed [OUT_SCORE_W-1:0] speech_end_score;
   logic        [IDX_W-1:0]       frame_index;

   modport source (output valid, survivor_bits, silence_end_score, speech_end_score,
                   frame_index, input ready);
   modport sink (input valid, survivor_bits, silence_end_score, speech_end_score,
                 frame_index, output ready);
endinterface

interface tcv_csr_if import tcv_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] speech_entry_penalty;

   modport source (output valid, speech_entry_penalty, input ready);
   modport sink (input valid, speech_entry_penalty, output ready);
endinterface

### rtl/two_class_viterbi_acs.sv
// A frame accepted on the request channel is held in the input stage; it moves
// to the result stage, which offers it on the result channel, once that is free.
// Throughput: one frame per cycle while the result channel is not stalled; the path
// score registers close the recursion through one add-compare-select cell per state.
// Reset (synchronous, active high) clears the frame counter, the penalty and
// both channel stages; the first frame after reset starts a new session.
// ----------------------------------------------------------------------------
// Two-class Viterbi ACS
// Forward Viterbi recursion over a silence chain and a speech chain.
// ----------------------------------------------------------------------------
module two_class_viterbi_acs import tcv_pkg::*; #(
   parameter int STATES_PER_CLASS = STATES_PER_CLASS_DEF,
   parameter int SCORE_WIDTH      = SCORE_WIDTH_DEF
) (
   input logic       clock,
   input logic       reset,
   tcv_req_if.sink   req_chan,
   tcv_rsp_if.source rsp_chan,
   tcv_csr_if.sink   csr_chan
);

   localparam int NUM_ST = 2 * STATES_PER_CLASS;
   localparam int EXT_W  = (SCORE_WIDTH > OUT_SCORE_W) ? SCORE_WIDTH : OUT_SCORE_W;
   localparam logic signed [EXT_W-1:0] OUT_MAX = EXT_W'({1'b0, {(OUT_SCORE_W-1){1'b1}}});
   localparam logic signed [EXT_W-1:0] OUT_MIN = -OUT_MAX - EXT_W'(1);

   function automatic logic signed [OUT_SCORE_W-1:0] to_out(
      input logic signed [SCORE_WIDTH-1:0] s);
      logic signed [EXT_W-1:0]       e;
      logic signed [OUT_SCORE_W-1:0] r;
      e = EXT_W'(s);
      if (e > OUT_MAX) begin
         r = OUT_MAX[OUT_SCORE_W-1:0];
      end else if (e < OUT_MIN) begin
         r = OUT_MIN[OUT_SCORE_W-1:0];
      end else begin
         r = e[OUT_SCORE_W-1:0];
      end
      return r;
   endfunction

   // Input stage.
   logic                      in_valid_ff;
   logic signed [FIELD_W-1:0] sil_ff;
   logic signed [FIELD_W-1:0] sp_ff;
   logic                      ns_ff;
   logic signed [FIELD_W-1:0] pen_ff;

   // Recursion state.
   logic signed [SCORE_WIDTH-1:0] path_ff [NUM_ST];
   logic signed [SCORE_WIDTH-1:0] path_in [NUM_ST];
   logic        [IDX_W-1:0]       count_ff;
   logic        [IDX_W-1:0]       count_in;
   logic        [NUM_ST-1:0]      surv_all;
   logic        [SURV_W-1:0]      surv16;

   // Result stage.
   logic                          out_valid_ff;
   logic        [SURV_W-1:0]      surv_ff;
   logic signed [OUT_SCORE_W-1:0] sil_end_ff;
   logic signed [OUT_SCORE_W-1:0] sp_end_ff;
   logic        [IDX_W-1:0]       idx_ff;

   logic             acs_fire;
   logic [IDX_W-1:0] frame_t;
   logic             t_ge_n;

   assign acs_fire         = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready   = !in_valid_ff || acs_fire;
   assign csr_chan.ready   = 1'b1;
   assign frame_t          = ns_ff ? '0 : count_ff;
   assign t_ge_n           = (frame_t >= IDX_W'(STATES_PER_CLASS));
   assign count_in         = (&frame_t) ? frame_t : frame_t + IDX_W'(1);

   for (genvar c = 0; c < 2; c++) begin : g_chain
      for (genvar j = 0; j < STATES_PER_CLASS; j++) begin : g_state
         localparam int K = c * STATES_PER_CLASS + j;
         acs_ctrl_type                  ctrl;
         logic signed [SCORE_WIDTH-1:0] left_score;
         logic signed [FIELD_W-1:0]     left_delta;

         assign ctrl.first   = (frame_t == '0);
         assign ctrl.self_ok = (frame_t > IDX_W'(j));
         if (j == 0) begin : g_head
            // The head is entered from the last state of the other chain.
            assign ctrl.left_ok = t_ge_n;
            assign left_score   = path_ff[(1 - c) * STATES_PER_CLASS + STATES_PER_CLASS - 1];
            assign left_delta   = (c == 1) ? pen_ff : '0;
         end else begin : g_body
            assign ctrl.left_ok = 1'b1;
            assign left_score   = path_ff[K - 1];
            assign left_delta   = '0;
         end

         tcv_acs_cell #(
            .SCORE_W (SCORE_WIDTH),
            .IS_HEAD (j == 0)
         ) u_cell (
            .ctrl       (ctrl),
            .self_score (path_ff[K]),
            .left_score (left_score),
            .left_delta (left_delta),
            .emit       ((c == 1) ? sp_ff : sil_ff),
            .score_out  (path_in[K]),
            .took_left  (surv_all[K])
         );
      end
   end

   // Survivor bits of states at index sixteen and above are dropped.
   for (genvar k = 0; k < SURV_W; k++) begin : g_surv
      if (k < NUM_ST) begin : g_used
         assign surv16[k] = surv_all[k];
      end else begin : g_pad
         assign surv16[k] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
         pen_ff       <= '0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (acs_fire) begin
            out_valid_ff <= 1'b1;
            count_ff     <= count_in;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_chan.valid) begin
            pen_ff <= csr_chan.speech_entry_penalty;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         sil_ff <= req_chan.silence_score;
         sp_ff  <= req_chan.speech_score;
         ns_ff  <= req_chan.new_session;
      end
      if (acs_fire) begin
         for (int k = 0; k < NUM_ST; k++) begin
            path_ff[k] <= path_in[k];
         end
         surv_ff    <= surv16;
         sil_end_ff <= to_out(path_in[STATES_PER_CLASS - 1]);
         sp_end_ff  <= to_out(path_in[NUM_ST - 1]);
         idx_ff     <= frame_t;
      end
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.survivor_bits     = surv_ff;
   assign rsp_chan.silence_end_score = sil_end_ff;
   assign rsp_chan.speech_end_score  = sp_end_ff;
   assign rsp_chan.frame_index       = idx_ff;

endmodule

### rtl/tcv_acs_cell.sv
// ----------------------------------------------------------------------------
// Two-class Viterbi ACS cell
// Add-compare-select for one HMM state with saturating score arithmetic.
// ----------------------------------------------------------------------------
module tcv_acs_cell import tcv_pkg::*; #(
   parameter int SCORE_W = SCORE_WIDTH_DEF,
   parameter bit IS_HEAD = 1'b0
) (
   input  acs_ctrl_type              ctrl,
   input  logic signed [SCORE_W-1:0] self_score,
   input  logic signed [SCORE_W-1:0] left_score,
   input  logic signed [FIELD_W-1:0] left_delta,
   input  logic signed [FIELD_W-1:0] emit,
   output logic signed [SCORE_W-1:0] score_out,
   output logic                      took_left
);

   localparam int SUM_W = ((SCORE_W > FIELD_W) ? SCORE_W : FIELD_W) + 1;
   localparam logic signed [SCORE_W-1:0] S_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
   localparam logic signed [SCORE_W-1:0] S_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
   localparam logic signed [SUM_W-1:0] S_MAX_X = SUM_W'(S_MAX);
   localparam logic signed [SUM_W-1:0] S_MIN_X = SUM_W'(S_MIN);

   function automatic logic signed [SCORE_W-1:0] clamp_sum(input logic signed [SUM_W-1:0] s);
      logic signed [SCORE_W-1:0] r;
      if (s > S_MAX_X) begin
         r = S_MAX;
      end else if (s < S_MIN_X) begin
         r = S_MIN;
      end else begin
         r = s[SCORE_W-1:0];
      end
      return r;
   endfunction

   // The most negative score marks an impossible path and stays impossible.
   function automatic logic signed [SCORE_W-1:0] sat_add(input logic signed [SCORE_W-1:0] path,
                                                         input logic signed [FIELD_W-1:0] delta);
      logic signed [SUM_W-1:0] s;
      s = SUM_W'(path) + SUM_W'(delta);
      return (path == S_MIN) ? S_MIN : clamp_sum(s);
   endfunction

   logic signed [SCORE_W-1:0] self_v;
   logic signed [SCORE_W-1:0] left_v;
   logic signed [SCORE_W-1:0] acs_v;
   logic signed [SCORE_W-1:0] first_v;
   logic                      take_left;

   always_comb begin
      self_v    = ctrl.self_ok ? self_score : S_MIN;
      left_v    = ctrl.left_ok ? sat_add(left_score, left_delta) : S_MIN;
      // A tie keeps the self path.
      take_left = (left_v > self_v);
      acs_v     = sat_add(take_left ? left_v : self_v, emit);
      first_v   = IS_HEAD ? sat_add(clamp_sum(SUM_W'(emit)), left_delta) : S_MIN;
      score_out = ctrl.first ? first_v : acs_v;
      took_left = !ctrl.first && take_left;
   end

endmodule

### rtl/tcv_checker.sv
// ----------------------------------------------------------------------------
// Two-class Viterbi ACS checker
// Port-level assertions on the two-class Viterbi block, bound to its top.
// ----------------------------------------------------------------------------
`include "two_class_viterbi_acs_defines.svh"

module tcv_checker import tcv_pkg::*; #(
   parameter int STATES_PER_CLASS = STATES_PER_CLASS_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [SURV_W-1:0] survivor_bits,
   input logic [IDX_W-1:0]  frame_index
);

   // A stalled result stays offered.
   `TCV_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")

   // Reset empties the result stage.
   `TCV_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid, "result valid after reset")

   // The first frame of a session has no survivors.
   `TCV_ASSERT(a_first_surv, clock, reset, rsp_valid && (frame_index == '0) |-> (survivor_bits == '0), "survivors on first frame")

   // The silence head can only take the cross-chain path after a full chain of frames.
   `TCV_ASSERT(a_head_entry, clock, reset, rsp_valid && survivor_bits[0] |-> (frame_index >= IDX_W'(STATES_PER_CLASS)), "early chain entry")

endmodule

bind two_class_viterbi_acs tcv_checker #(
   .STATES_PER_CLASS (STATES_PER_CLASS)
) u_tcv_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .survivor_bits (rsp_chan.survivor_bits),
   .frame_index   (rsp_chan.frame_index)
);
